@@ design/rri_pkg.sv @@
// Shared types and constants of the ray/rectangle intersection unit.
`default_nettype none
package rri_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int EPSILON_Q16 = 66;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 3;
  localparam int DATA_W      = 64;
  localparam int LEN_W       = 63;
  localparam int Q_BITS      = 31;
  localparam int DEN_W       = 64;
  localparam int NUM_W       = 65 + FRAC_BITS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CORNER_XY,
    REG_CORNER_Z_EDGE_A_X,
    REG_EDGE_A_YZ,
    REG_EDGE_B_XY,
    REG_EDGE_B_Z_NORMAL_X,
    REG_NORMAL_YZ,
    REG_EDGE_A_LEN_SQ,
    REG_EDGE_B_LEN_SQ
  } reg_idx_e;

  localparam logic [NUM_REGS-1:0][DATA_W-1:0] REG_RESET = {
    64'h0000_0004_0000_0000, 64'h0000_0004_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0002_0000_0000_0000, 64'h0000_0000_0002_0000,
    64'hFFFF_0000_0000_0000, 64'hFFFF_0000_0000_0000
  };

  typedef struct packed {
    logic [2:0][31:0]  c;
    logic [2:0][31:0]  a;
    logic [2:0][31:0]  b;
    logic [2:0][31:0]  n;
    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  len_b;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
  } ray_t;

  typedef struct packed {
    ray_t             ray;
    logic             miss;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } frac_t;

  typedef struct packed {
    ray_t              ray;
    logic              miss;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem;
    logic [Q_BITS-1:0] low;
    logic [Q_BITS-1:0] q;
  } div_t;

  typedef struct packed {
    ray_t              ray;
    logic              miss;
    logic [Q_BITS-1:0] t;
  } tval_t;

  typedef struct packed {
    logic              hit;
    logic [Q_BITS-1:0] distance;
    logic [2:0][31:0]  p;
  } res_t;

endpackage
`default_nettype wire

@@ design/rri_channels.sv @@
// Ray input and result output channel interfaces.
`default_nettype none
interface rri_ray_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rri_res_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [30:0]        distance;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, hit, distance, point_x, point_y, point_z, input ready);
  modport sink (input valid, hit, distance, point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

@@ design/rri_regs.sv @@
// APB register file holding the rectangle geometry.
`default_nettype none
module rri_regs import rri_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  logic [NUM_REGS-1:0][DATA_W-1:0] regs_q;
  reg_idx_e                        idx;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:3]);
  assign pready = 1'b1;
  assign prdata = regs_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= REG_RESET;
    end else if (psel && penable && pwrite) begin
      if (idx == REG_EDGE_A_LEN_SQ || idx == REG_EDGE_B_LEN_SQ) begin
        regs_q[idx] <= {1'b0, pwdata[LEN_W-1:0]};
      end else begin
        regs_q[idx] <= pwdata;
      end
    end
  end

  always_comb begin
    cfg_o.c[0]  = regs_q[REG_CORNER_XY][63:32];
    cfg_o.c[1]  = regs_q[REG_CORNER_XY][31:0];
    cfg_o.c[2]  = regs_q[REG_CORNER_Z_EDGE_A_X][63:32];
    cfg_o.a[0]  = regs_q[REG_CORNER_Z_EDGE_A_X][31:0];
    cfg_o.a[1]  = regs_q[REG_EDGE_A_YZ][63:32];
    cfg_o.a[2]  = regs_q[REG_EDGE_A_YZ][31:0];
    cfg_o.b[0]  = regs_q[REG_EDGE_B_XY][63:32];
    cfg_o.b[1]  = regs_q[REG_EDGE_B_XY][31:0];
    cfg_o.b[2]  = regs_q[REG_EDGE_B_Z_NORMAL_X][63:32];
    cfg_o.n[0]  = regs_q[REG_EDGE_B_Z_NORMAL_X][31:0];
    cfg_o.n[1]  = regs_q[REG_NORMAL_YZ][63:32];
    cfg_o.n[2]  = regs_q[REG_NORMAL_YZ][31:0];
    cfg_o.len_a = regs_q[REG_EDGE_A_LEN_SQ][LEN_W-1:0];
    cfg_o.len_b = regs_q[REG_EDGE_B_LEN_SQ][LEN_W-1:0];
  end

endmodule
`default_nettype wire

@@ design/rri_front.sv @@
// Front pipeline: plane dot products, sign checks and divider operands.
`default_nettype none
module rri_front import rri_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  ray_t       in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output frac_t      out_data_o
);

  localparam int NS = 4;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  ray_t             ray1_q, ray2_q, ray3_q;
  logic [2:0][32:0] diff_d, diff1_q;
  logic [2:0][63:0] pd_d, pd2_q;
  logic [2:0][64:0] pn_d, pn2_q;
  logic [65:0]      den_d, den3_q, den_neg;
  logic [66:0]      num_d, num3_q, num_neg;
  frac_t            out_d, out_q;

  assign rdy[NS] = out_ready_i;
  assign v_d     = {v_q[NS-2:0], in_valid_i};
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_d[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = {cfg_i.c[i][31], cfg_i.c[i]} - {in_data_i.o[i][31], in_data_i.o[i]};
      pd_d[i]   = $signed(ray1_q.d[i]) * $signed(cfg_i.n[i]);
      pn_d[i]   = $signed(diff1_q[i]) * $signed(cfg_i.n[i]);
    end
    den_d = $signed(pd2_q[0]) + $signed(pd2_q[1]) + $signed(pd2_q[2]);
    num_d = $signed(pn2_q[0]) + $signed(pn2_q[1]) + $signed(pn2_q[2]);
  end

  always_comb begin
    den_neg        = -den3_q;
    num_neg        = -num3_q;
    out_d.ray      = ray3_q;
    out_d.miss     = (den3_q == '0) || (num3_q == '0) || (den3_q[65] != num3_q[66]);
    out_d.den      = den3_q[65] ? den_neg[DEN_W-1:0] : den3_q[DEN_W-1:0];
    out_d.num      = {(num3_q[66] ? num_neg[64:0] : num3_q[64:0]), {FRAC_BITS{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ray1_q  <= in_data_i;
      diff1_q <= diff_d;
    end
    if (rdy[1]) begin
      ray2_q <= ray1_q;
      pd2_q  <= pd_d;
      pn2_q  <= pn_d;
    end
    if (rdy[2]) begin
      ray3_q <= ray2_q;
      den3_q <= den_d;
      num3_q <= num_d;
    end
    if (rdy[3]) out_q <= out_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ design/rri_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
`default_nettype none
module rri_div import rri_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  frac_t      in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output tval_t      out_data_o
);

  localparam int NS = Q_BITS + 1;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;
  div_t          st_d [NS];
  div_t          st_q [NS];

  assign rdy[NS] = out_ready_i;
  assign v_d     = {v_q[NS-2:0], in_valid_i};
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_d[k];
      end
    end
  end

  // entry: quotient must fit in Q_BITS, i.e. num >> Q_BITS below den
  always_comb begin
    st_d[0].ray  = in_data_i.ray;
    st_d[0].den  = in_data_i.den;
    st_d[0].rem  = DEN_W'(in_data_i.num[NUM_W-1:Q_BITS]);
    st_d[0].low  = in_data_i.num[Q_BITS-1:0];
    st_d[0].q    = '0;
    st_d[0].miss = in_data_i.miss ||
                   (DEN_W'(in_data_i.num[NUM_W-1:Q_BITS]) >= in_data_i.den);
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [DEN_W:0] r2, r2_sub;
    logic           ge;
    always_comb begin
      r2          = {st_q[k-1].rem, st_q[k-1].low[Q_BITS-1]};
      r2_sub      = r2 - {1'b0, st_q[k-1].den};
      ge          = r2 >= {1'b0, st_q[k-1].den};
      st_d[k]     = st_q[k-1];
      st_d[k].rem = ge ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
      st_d[k].low = {st_q[k-1].low[Q_BITS-2:0], 1'b0};
      st_d[k].q   = {st_q[k-1].q[Q_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) st_q[k] <= st_d[k];
    end
  end

  assign in_ready_o      = rdy[0];
  assign out_valid_o     = v_q[NS-1];
  assign out_data_o.ray  = st_q[NS-1].ray;
  assign out_data_o.miss = st_q[NS-1].miss;
  assign out_data_o.t    = st_q[NS-1].q;

endmodule
`default_nettype wire

@@ design/rri_point.sv @@
// Back pipeline: hit point, range checks and edge projections.
`default_nettype none
module rri_point import rri_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  cfg_t       cfg_i,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  tval_t      in_data_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output res_t       out_data_o
);

  localparam int NS = 4;

  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;

  logic [Q_BITS-1:0] t1_q, t2_q, t3_q;
  ray_t              ray1_q;
  logic              miss1_q, miss2_q, miss3_q, miss_d1, miss_d2;
  logic [2:0][63:0]  prod_d, prod1_q;
  logic signed [64:0] p_w [3];
  logic [2:0][31:0]  p_d, p2_q, p3_q;
  logic [2:0][32:0]  dd_d, dd2_q;
  logic [2:0][64:0]  pa_d, pb_d, pa3_q, pb3_q;
  logic [66:0]       sa, sb;
  logic              hit;
  res_t              out_d, out_q;

  assign rdy[NS] = out_ready_i;
  assign v_d     = {v_q[NS-2:0], in_valid_i};
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_d[k];
      end
    end
  end

  always_comb begin
    miss_d1 = in_data_i.miss || (in_data_i.t <= Q_BITS'(EPSILON_Q16));
    miss_d2 = miss1_q;
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = $signed({1'b0, in_data_i.t}) * $signed(in_data_i.ray.d[i]);
      p_w[i]    = $signed({{33{ray1_q.o[i][31]}}, ray1_q.o[i]})
                  + ($signed(prod1_q[i]) >>> FRAC_BITS);
      p_d[i]    = p_w[i][31:0];
      dd_d[i]   = {p_w[i][31], p_w[i][31:0]} - {cfg_i.c[i][31], cfg_i.c[i]};
      if (p_w[i][64:31] != '0 && p_w[i][64:31] != '1) miss_d2 = 1'b1;
      pa_d[i]   = $signed(dd2_q[i]) * $signed(cfg_i.a[i]);
      pb_d[i]   = $signed(dd2_q[i]) * $signed(cfg_i.b[i]);
    end
  end

  always_comb begin
    sa  = $signed(pa3_q[0]) + $signed(pa3_q[1]) + $signed(pa3_q[2]);
    sb  = $signed(pb3_q[0]) + $signed(pb3_q[1]) + $signed(pb3_q[2]);
    hit = !miss3_q
          && !sa[66] && (sa <= {4'b0, cfg_i.len_a})
          && !sb[66] && (sb <= {4'b0, cfg_i.len_b});
    out_d.hit      = hit;
    out_d.distance = hit ? t3_q : '0;
    out_d.p        = hit ? p3_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      t1_q    <= in_data_i.t;
      ray1_q  <= in_data_i.ray;
      miss1_q <= miss_d1;
      prod1_q <= prod_d;
    end
    if (rdy[1]) begin
      t2_q    <= t1_q;
      miss2_q <= miss_d2;
      p2_q    <= p_d;
      dd2_q   <= dd_d;
    end
    if (rdy[2]) begin
      t3_q    <= t2_q;
      miss3_q <= miss2_q;
      p3_q    <= p2_q;
      pa3_q   <= pa_d;
      pb3_q   <= pb_d;
    end
    if (rdy[3]) out_q <= out_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ design/ray_rectangle_intersect_unit.sv @@
// Ray/rectangle intersection unit: top level.
// Usage:
//   ray_i carries one ray (origin, direction, signed Q16.16) per transfer;
//   res_o returns exactly one result per ray, in order: hit flag, distance t
//   (unsigned Q15.16) and hit point, all zero on a miss.
//   The APB port holds the rectangle geometry; write it only while no ray
//   is in flight. pready is always high, reads return the register value.
// Timing:
//   A ray passes the plane dot product stages, then 32 divider stages (an
//   overflow check, then one quotient bit each), then the hit point and edge
//   projection stages. Throughput is one ray per cycle while res_o accepts
//   results, set by the fully pipelined divider.
// Reset and stalls:
//   rst_ni clears all stage valids and loads the default geometry.
//   A stalled receiver holds the result; stages behind it keep filling
//   empty slots, so ray_i.ready drops only when the whole pipe is full.
`default_nettype none
module ray_rectangle_intersect_unit import rri_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  rri_ray_if.sink                ray_i,
  rri_res_if.source              res_o
);

  cfg_t  cfg;
  ray_t  ray_in;
  frac_t frac;
  tval_t tval;
  res_t  res;
  logic  frac_valid, frac_ready, tval_valid, tval_ready;

  assign ray_in.o = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign ray_in.d = {ray_i.dir_z, ray_i.dir_y, ray_i.dir_x};

  rri_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  rri_front u_front (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (ray_i.valid),
    .in_ready_o  (ray_i.ready),
    .in_data_i   (ray_in),
    .out_valid_o (frac_valid),
    .out_ready_i (frac_ready),
    .out_data_o  (frac)
  );

  rri_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i  (frac_valid),
    .in_ready_o  (frac_ready),
    .in_data_i   (frac),
    .out_valid_o (tval_valid),
    .out_ready_i (tval_ready),
    .out_data_o  (tval)
  );

  rri_point u_point (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .in_valid_i  (tval_valid),
    .in_ready_o  (tval_ready),
    .in_data_i   (tval),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (res)
  );

  assign res_o.hit      = res.hit;
  assign res_o.distance = res.distance;
  assign res_o.point_x  = res.p[0];
  assign res_o.point_y  = res.p[1];
  assign res_o.point_z  = res.p[2];

endmodule
`default_nettype wire

@@ bench/ray_rectangle_intersect_unit_tb.sv @@
// Ray/rectangle intersection unit testbench: directed and random rays with bit-exact prediction.
module ray_rectangle_intersect_unit_tb;
  import rri_pkg::*;

  localparam int           LIMIT = 400000;
  localparam logic [31:0]  ONE   = 32'h0001_0000;
  localparam logic signed [127:0] P_MIN = -128'sd2147483648;
  localparam logic signed [127:0] P_MAX = 128'sd2147483647;

  class rect_scoreboard;
    logic [DATA_W-1:0] geom [NUM_REGS];
    res_t hit_q [$];

    function logic signed [127:0] sx(logic [31:0] v);
      return {{96{v[31]}}, v};
    endfunction

    function logic signed [127:0] dot3(logic signed [127:0] x0, x1, x2, y0, y1, y2);
      return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    function res_t trace(ray_t r);
      logic signed [127:0] c [3], a [3], b [3], n [3], o [3], d [3], p [3], dd [3];
      logic signed [127:0] den, num, ts, proj, len_a, len_b;
      logic [127:0] un, ud, q;
      res_t z;
      z = '0;
      c[0] = sx(geom[REG_CORNER_XY][63:32]);   c[1] = sx(geom[REG_CORNER_XY][31:0]);
      c[2] = sx(geom[REG_CORNER_Z_EDGE_A_X][63:32]);
      a[0] = sx(geom[REG_CORNER_Z_EDGE_A_X][31:0]);
      a[1] = sx(geom[REG_EDGE_A_YZ][63:32]);   a[2] = sx(geom[REG_EDGE_A_YZ][31:0]);
      b[0] = sx(geom[REG_EDGE_B_XY][63:32]);   b[1] = sx(geom[REG_EDGE_B_XY][31:0]);
      b[2] = sx(geom[REG_EDGE_B_Z_NORMAL_X][63:32]);
      n[0] = sx(geom[REG_EDGE_B_Z_NORMAL_X][31:0]);
      n[1] = sx(geom[REG_NORMAL_YZ][63:32]);   n[2] = sx(geom[REG_NORMAL_YZ][31:0]);
      len_a = {65'd0, geom[REG_EDGE_A_LEN_SQ][62:0]};
      len_b = {65'd0, geom[REG_EDGE_B_LEN_SQ][62:0]};
      for (int i = 0; i < 3; i++) begin
        o[i] = sx(r.o[i]);
        d[i] = sx(r.d[i]);
      end
      den = dot3(d[0], d[1], d[2], n[0], n[1], n[2]);
      if (den == 0) return z;
      num = dot3(c[0] - o[0], c[1] - o[1], c[2] - o[2], n[0], n[1], n[2]);
      if (num == 0 || num[127] != den[127]) return z;
      un = num[127] ? -num : num;
      ud = den[127] ? -den : den;
      q = (un << FRAC_BITS) / ud;
      if (q > 128'h7FFF_FFFF || q <= EPSILON_Q16) return z;
      ts = q;
      for (int i = 0; i < 3; i++) begin
        p[i] = o[i] + ((ts * d[i]) >>> FRAC_BITS);
        if (p[i] < P_MIN || p[i] > P_MAX) return z;
        dd[i] = p[i] - c[i];
      end
      proj = dot3(dd[0], dd[1], dd[2], a[0], a[1], a[2]);
      if (proj < 0 || proj > len_a) return z;
      proj = dot3(dd[0], dd[1], dd[2], b[0], b[1], b[2]);
      if (proj < 0 || proj > len_b) return z;
      z.hit = 1'b1;
      z.distance = q[30:0];
      for (int i = 0; i < 3; i++) z.p[i] = p[i][31:0];
      return z;
    endfunction

    function void note_ray(ray_t r);
      hit_q.push_back(trace(r));
    endfunction

    function string check_result(res_t got);
      res_t want;
      string msg;
      msg = "";
      if (hit_q.size() == 0) return "result with no ray outstanding";
      want = hit_q.pop_front();
      if (got.hit !== want.hit)
        msg = {msg, $sformatf(" hit %0b/%0b", got.hit, want.hit)};
      if (got.distance !== want.distance)
        msg = {msg, $sformatf(" distance %h/%h", got.distance, want.distance)};
      for (int i = 0; i < 3; i++)
        if (got.p[i] !== want.p[i])
          msg = {msg, $sformatf(" point[%0d] %h/%h", i, got.p[i], want.p[i])};
      return msg;
    endfunction
  endclass

  logic              clk_i, rst_ni;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  logic              pready;
  rri_ray_if ray_ch();
  rri_res_if res_ch();

  ray_rectangle_intersect_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .ray_i(ray_ch.sink), .res_o(res_ch.source)
  );

  rect_scoreboard sb;
  int errors, cycles, send_idle_pct, recv_stall_pct, hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report(string msg);
    errors++;
    $display("mismatch at cycle %0d:%s", cycles, msg);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ray_rectangle_intersect_unit test failed");
      $finish;
    end
  end

  // result side: check each transfer, then pick next ready
  always @(posedge clk_i) begin
    res_t got;
    string msg;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.hit = res_ch.hit;
      got.distance = res_ch.distance;
      got.p[0] = res_ch.point_x;
      got.p[1] = res_ch.point_y;
      got.p[2] = res_ch.point_z;
      msg = sb.check_result(got);
      if (msg != "") report(msg);
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.geom[idx] = (idx >= REG_EDGE_A_LEN_SQ) ? {1'b0, val[62:0]} : val;
  endtask

  // entered at a clock edge; returns at the edge of the transfer
  task automatic send_ray(ray_t r);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      ray_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= r.o[0]; ray_ch.origin_y <= r.o[1]; ray_ch.origin_z <= r.o[2];
    ray_ch.dir_x <= r.d[0];    ray_ch.dir_y <= r.d[1];    ray_ch.dir_z <= r.d[2];
    do @(posedge clk_i); while (!ray_ch.ready);
    sb.note_ray(r);
  endtask

  task automatic drain();
    ray_ch.valid <= 1'b0;
    while (sb.hit_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic ray_t mk(logic [31:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
    r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
    return r;
  endfunction

  function automatic logic [31:0] rnd_small(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // random rectangle: edges small; unless extreme, normal = cross(a, b), lengths exact
  task automatic load_geometry(bit extreme);
    longint a [3], b [3], c [3], n [3];
    longint la, lb;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(rnd_small(1 << 18)));
      b[i] = longint'($signed(rnd_small(1 << 18)));
      c[i] = longint'($signed(rnd_small(1 << 22)));
    end
    if ($urandom_range(0, 1)) begin
      a[1] = 0; a[2] = 0; b[0] = 0; b[2] = 0;
    end
    n[0] = (a[1] * b[2] - a[2] * b[1]) >>> 16;
    n[1] = (a[2] * b[0] - a[0] * b[2]) >>> 16;
    n[2] = (a[0] * b[1] - a[1] * b[0]) >>> 16;
    la = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    lb = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
    if (extreme) begin
      c[0] = -64'sd2147483648; c[1] = 64'sd2147483647;
      n[0] = 64'sd2147483647;  n[1] = -64'sd2147483648; n[2] = 1;
      la = 64'h7FFF_FFFF_FFFF_FFFF; lb = 0;
    end
    apb_write(REG_CORNER_XY, {32'(c[0]), 32'(c[1])});
    apb_write(REG_CORNER_Z_EDGE_A_X, {32'(c[2]), 32'(a[0])});
    apb_write(REG_EDGE_A_YZ, {32'(a[1]), 32'(a[2])});
    apb_write(REG_EDGE_B_XY, {32'(b[0]), 32'(b[1])});
    apb_write(REG_EDGE_B_Z_NORMAL_X, {32'(b[2]), 32'(n[0])});
    apb_write(REG_NORMAL_YZ, {32'(n[1]), 32'(n[2])});
    apb_write(REG_EDGE_A_LEN_SQ, 64'(la));
    apb_write(REG_EDGE_B_LEN_SQ, extreme ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(lb));
  endtask

  // aim at a random point of the current rectangle from a random origin
  function automatic ray_t aimed_ray();
    longint c [3], a [3], b [3], tgt [3], o [3];
    longint u, v;
    ray_t r;
    c[0] = longint'($signed(sb.geom[REG_CORNER_XY][63:32]));
    c[1] = longint'($signed(sb.geom[REG_CORNER_XY][31:0]));
    c[2] = longint'($signed(sb.geom[REG_CORNER_Z_EDGE_A_X][63:32]));
    a[0] = longint'($signed(sb.geom[REG_CORNER_Z_EDGE_A_X][31:0]));
    a[1] = longint'($signed(sb.geom[REG_EDGE_A_YZ][63:32]));
    a[2] = longint'($signed(sb.geom[REG_EDGE_A_YZ][31:0]));
    b[0] = longint'($signed(sb.geom[REG_EDGE_B_XY][63:32]));
    b[1] = longint'($signed(sb.geom[REG_EDGE_B_XY][31:0]));
    b[2] = longint'($signed(sb.geom[REG_EDGE_B_Z_NORMAL_X][63:32]));
    u = $urandom_range(0, 1 << 16);
    v = $urandom_range(0, 1 << 16);
    for (int i = 0; i < 3; i++) begin
      tgt[i] = c[i] + ((a[i] * u) >>> 16) + ((b[i] * v) >>> 16);
      o[i] = longint'($signed(rnd_small(1 << 24)));
      r.o[i] = 32'(o[i]);
      r.d[i] = 32'(tgt[i] - o[i]);
    end
    return r;
  endfunction

  function automatic ray_t noise_ray();
    return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic run_phase(int count);
    for (int k = 0; k < count; k++)
      send_ray(($urandom_range(0, 99) < 80) ? aimed_ray() : noise_ray());
  endtask

  initial begin
    sb = new();
    for (int i = 0; i < NUM_REGS; i++) sb.geom[i] = REG_RESET[i];
    errors = 0; cycles = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    res_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: 2 x 2 square centred on the origin in the y = 0 plane
    send_ray(mk(0, 5 * ONE, 0, 0, -ONE, 0));
    send_ray(mk(0, 5 * ONE, 0, ONE, 0, 0));
    send_ray(mk(0, 5 * ONE, 0, 0, ONE, 0));
    send_ray(mk(0, 0, 0, 0, -ONE, 0));
    send_ray(mk(0, 66, 0, 0, -ONE, 0));
    send_ray(mk(0, 67, 0, 0, -ONE, 0));
    send_ray(mk(0, 32'h7FFF_FFFF, 0, 0, -1, 0));
    send_ray(mk(32'h7FFF_FFFF, ONE, 0, ONE, -ONE, 0));
    send_ray(mk(-ONE, 5 * ONE, -ONE, 0, -ONE, 0));
    send_ray(mk(ONE, 5 * ONE, ONE, 0, -ONE, 0));
    send_ray(mk(ONE + 1, 5 * ONE, ONE, 0, -ONE, 0));
    send_ray(mk(2 * ONE, 5 * ONE, 0, 0, -ONE, 0));
    send_ray(mk(0, 5 * ONE, -ONE - 1, 0, -ONE, 0));
    send_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_ray(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_ray(mk(0, 0, 0, 0, 0, 0));
    send_ray(mk(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_ray(mk(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0));
    send_ray(mk(0, 2 * ONE, 0, ONE / 2, -ONE, ONE / 4));
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      load_geometry(ph == 4);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
      end
      run_phase(92);
      drain();
    end

    if (errors == 0) begin
      $display("ray_rectangle_intersect_unit test passed");
    end else begin
      $display("ray_rectangle_intersect_unit test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/rri_pkg.sv
design/rri_channels.sv
design/rri_regs.sv
design/rri_front.sv
design/rri_div.sv
design/rri_point.sv
design/ray_rectangle_intersect_unit.sv
bench/ray_rectangle_intersect_unit_tb.sv
